FILE: hdl/srle_pkg.sv
`default_nettype none

package srle_pkg;

	localparam int MAX_DIM = 1024;
	localparam int DIM_W   = 11;
	localparam int DIM_LIM = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
	localparam int POS_W   = 10;
	localparam int REM_W   = 7;
	localparam int IDX_W   = 6;

	localparam logic [1:0] MODE_FILL = 2'd0;
	localparam logic [1:0] MODE_ODD  = 2'd1;
	localparam logic [1:0] MODE_COPY = 2'd2;
	localparam logic [1:0] MODE_SKIP = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_RUN  = 2'd1;
	localparam logic [1:0] ERR_EOD  = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_CTRL,
		ST_VALUE,
		ST_LIT,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic take_ctrl;
		logic take_value;
		logic take_lit;
		logic run_step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] ctrl_mode;
		logic       lit_last;
		logic       run_last;
		logic       restart;
	} stat_t;

	function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(DIM_LIM))
			r = DIM_W'(DIM_LIM);
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/srle_ctrl.sv
`default_nettype none

module srle_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_free,
	input  srle_pkg::stat_t     stat,
	output logic                in_ready,
	output srle_pkg::cmd_t      cmd
);

	srle_pkg::state_t state_q, state_d;
	logic             take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= srle_pkg::ST_CTRL;
		else
			state_q <= state_d;
	end

	always_comb begin
		in_ready = (state_q != srle_pkg::ST_RUN) && out_free;
		take     = in_valid && in_ready;
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			srle_pkg::ST_CTRL: begin
				cmd.take_ctrl = take;
				if (take && !stat.restart) begin
					if (stat.ctrl_mode == srle_pkg::MODE_COPY)
						state_d = srle_pkg::ST_LIT;
					else if (stat.ctrl_mode != srle_pkg::MODE_SKIP)
						state_d = srle_pkg::ST_VALUE;
				end
			end
			srle_pkg::ST_VALUE: begin
				cmd.take_value = take;
				if (take)
					state_d = srle_pkg::ST_RUN;
			end
			srle_pkg::ST_LIT: begin
				cmd.take_lit = take;
				if (take && (stat.lit_last || stat.restart))
					state_d = srle_pkg::ST_CTRL;
			end
			srle_pkg::ST_RUN: begin
				cmd.run_step = out_free;
				if (out_free && stat.run_last)
					state_d = srle_pkg::ST_CTRL;
			end
			default: state_d = srle_pkg::ST_CTRL;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/srle_dp.sv
`default_nettype none

module srle_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  srle_pkg::cmd_t                   cmd,
	input  wire logic [7:0]                  in_byte,
	input  wire logic                        in_eod,
	input  wire logic [srle_pkg::DIM_W-1:0]  width_reg,
	input  wire logic [srle_pkg::DIM_W-1:0]  height_reg,
	input  wire logic                        out_ready,
	output srle_pkg::stat_t                  stat,
	output logic                             out_free,
	output logic                             out_valid,
	output logic [31:0]                      out_data,
	output logic                             out_user,
	output logic                             out_last
);

	localparam int DW = srle_pkg::DIM_W;
	localparam int PW = srle_pkg::POS_W;
	localparam int RW = srle_pkg::REM_W;
	localparam int IW = srle_pkg::IDX_W;

	logic [DW-1:0] cur_col_q, cur_row_q;
	logic [RW-1:0] rem_q;
	logic [1:0]    mode_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    value_q;
	logic          eod_q;
	logic          out_valid_q;

	logic          wv_q, done_q, last_q;
	logic [PW-1:0] col_q, row_q;
	logic [7:0]    pix_q;
	logic [1:0]    err_q;

	logic [DW-1:0] w, h;
	logic [RW-1:0] count;
	logic [1:0]    mode;
	logic [RW:0]   span, run_span, inc;
	logic [RW-1:0] run_off;
	logic [DW-1:0] run_col;
	logic          over, run_last, lit_last, run_over, row_adv, done;
	logic          item_end, eod_cur, restart, load;
	logic [DW:0]   col_next;
	logic [DW-1:0] row_next;
	logic [1:0]    err;

	always_comb begin
		w        = srle_pkg::dim_limit(width_reg);
		h        = srle_pkg::dim_limit(height_reg);
		count    = {1'b0, in_byte[5:0]} + RW'(1);
		mode     = in_byte[7:6];
		span     = (mode == srle_pkg::MODE_ODD) ? {count, 1'b0} : {1'b0, count};
		over     = ({1'b0, cur_col_q} + (DW+1)'(span)) > {1'b0, w};
		run_span = (mode_q == srle_pkg::MODE_ODD) ? {rem_q, 1'b0} : {1'b0, rem_q};
		run_off  = (mode_q == srle_pkg::MODE_ODD) ? {idx_q, 1'b1} : {1'b0, idx_q};
		run_col  = cur_col_q + DW'(run_off);
		run_last = ({1'b0, idx_q} + RW'(1)) == rem_q;
		lit_last = rem_q == RW'(1);
		if (cmd.take_ctrl)
			inc = span;
		else if (cmd.take_lit)
			inc = (RW+1)'(1);
		else
			inc = run_span;
		col_next = {1'b0, cur_col_q} + (DW+1)'(inc);
		run_over = (cmd.take_ctrl && !over && mode == srle_pkg::MODE_SKIP)
			|| (cmd.take_lit && lit_last) || (cmd.run_step && run_last);
		row_adv  = run_over && (col_next >= {1'b0, w});
		row_next = cur_row_q + DW'(1);
		done     = row_adv && (row_next >= h);
		item_end = cmd.take_ctrl || cmd.take_lit || (cmd.run_step && run_last);
		eod_cur  = cmd.run_step ? eod_q : in_eod;
		if (cmd.take_ctrl && over)
			err = srle_pkg::ERR_RUN;
		else if (item_end && !done && eod_cur)
			err = srle_pkg::ERR_EOD;
		else
			err = srle_pkg::ERR_NONE;
		restart  = item_end && (done || err != srle_pkg::ERR_NONE);
		out_free = !out_valid_q || out_ready;
		load     = cmd.take_ctrl || cmd.take_lit || cmd.run_step;

		stat.ctrl_mode = mode;
		stat.lit_last  = lit_last;
		stat.run_last  = run_last;
		stat.restart   = restart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			rem_q       <= '0;
			mode_q      <= srle_pkg::MODE_FILL;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (restart) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
				rem_q     <= '0;
				mode_q    <= srle_pkg::MODE_FILL;
				idx_q     <= '0;
			end else begin
				if (row_adv) begin
					cur_col_q <= '0;
					cur_row_q <= row_next;
				end else if (run_over || cmd.take_lit) begin
					cur_col_q <= col_next[DW-1:0];
				end
				if (cmd.take_ctrl && !over && mode != srle_pkg::MODE_SKIP) begin
					rem_q <= count;
					idx_q <= '0;
					if (mode != srle_pkg::MODE_COPY)
						mode_q <= mode;
				end
				if (cmd.take_lit)
					rem_q <= rem_q - RW'(1);
				if (cmd.run_step)
					idx_q <= run_last ? '0 : idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_value) begin
			value_q <= in_byte;
			eod_q   <= in_eod;
		end
		if (load) begin
			wv_q   <= cmd.take_lit || cmd.run_step;
			col_q  <= cmd.take_lit ? cur_col_q[PW-1:0] :
				(cmd.run_step ? run_col[PW-1:0] : '0);
			row_q  <= (cmd.take_lit || cmd.run_step) ? cur_row_q[PW-1:0] : '0;
			pix_q  <= cmd.take_lit ? in_byte : (cmd.run_step ? value_q : 8'd0);
			done_q <= done;
			err_q  <= err;
			last_q <= item_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {1'b0, err_q, done_q, pix_q, row_q, col_q};
	assign out_user  = wv_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

FILE: hdl/sprite_rle_row_decoder.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata stream_byte, s_tlast end_of_data
// m_*       out  m_tvalid/m_tready  m_tdata col/row/value/done/error, m_tuser write_valid,
//                                   m_tlast last_result
// apb       in   psel/penable       frame_width at 0x0, frame_height at 0x4
//
// A control byte or literal byte is consumed as it is taken; a value byte then expands into its run
// (1 to 64 pixels), one pixel per output beat, paced by the single output register.
// A byte is taken while the output register is empty or being drained.
// Reset returns the decoder to frame start with both dimensions at 1.
// Output stalls hold the run in place; no input is taken during a run.
`default_nettype none

module sprite_rle_row_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [9:0] pixel_col, [19:10] pixel_row,
	                                    // [27:20] pixel_value, [28] frame_done,
	                                    // [30:29] error_code, [31] zero
	output logic             m_tuser,   // [0] write_valid
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [srle_pkg::DIM_W-1:0] width_q, height_q;
	srle_pkg::cmd_t             cmd;
	srle_pkg::stat_t            stat;
	logic                       out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= srle_pkg::DIM_W'(1);
			height_q <= srle_pkg::DIM_W'(1);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == srle_pkg::REG_HEIGHT)
				height_q <= pwdata[srle_pkg::DIM_W-1:0];
			else
				width_q <= pwdata[srle_pkg::DIM_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == srle_pkg::REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	srle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	srle_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_byte    (s_tdata),
		.in_eod     (s_tlast),
		.width_reg  (width_q),
		.height_reg (height_q),
		.out_ready  (m_tready),
		.stat       (stat),
		.out_free   (out_free),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata),
		.out_user   (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

`default_nettype wire
